// ===== rtl/core/bate_pkg.sv =====
// ----------------------------------------------------------------------------
// bate_pkg
// Shared types and constants for the bounded array table engine: channel
// payloads, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bate_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int WORD_W        = 32;
   localparam int DIV_W         = 17;   // trial divisors stay below 2^16 + 1
   localparam int SQ_W          = 33;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_LIST   = 3'd2,
      CMD_PRIMES = 3'd3,
      CMD_SORT   = 3'd4,
      CMD_DELETE = 3'd5,
      CMD_SEARCH = 3'd6
   } command_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_BADINDEX = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      command_type        command;
      logic signed [31:0] value;
      logic [5:0]         index;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [4:0]         position;
      logic signed [31:0] element;
      logic [5:0]         element_count;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {IOP_HOLD, IOP_ZERO, IOP_ONE, IOP_INDEX, IOP_INC} i_op_type;
   typedef enum logic [1:0] {JOP_HOLD, JOP_LOAD_I, JOP_DEC} j_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_INC, CNT_DEC} count_op_type;
   typedef enum logic [1:0] {RA_I, RA_I_PLUS, RA_J_MINUS} raddr_sel_type;
   typedef enum logic [1:0] {WA_COUNT, WA_I, WA_J} waddr_sel_type;
   typedef enum logic [1:0] {WD_VALUE, WD_RDATA, WD_KEY} wdata_sel_type;
   typedef enum logic [1:0] {PEND_HOLD, PEND_CLEAR, PEND_LOAD} pend_op_type;
   typedef enum logic [3:0] {
      EM_NONE, EM_CLEAR, EM_APPEND, EM_LIST, EM_EMPTY, EM_SORTED,
      EM_BADINDEX, EM_DELETE, EM_PEND, EM_PEND_LAST, EM_NOTFOUND
   } emit_type;

   typedef struct packed {
      logic          load_req;
      i_op_type      i_op;
      j_op_type      j_op;
      logic          key_load;
      count_op_type  count_op;
      raddr_sel_type raddr_sel;
      logic          we;
      waddr_sel_type waddr_sel;
      wdata_sel_type wdata_sel;
      pend_op_type   pend_op;
      logic          prime_init;
      logic          prime_step;
      logic          div_start;
      emit_type      emit;
   } dp_cmd_type;

   typedef struct packed {
      command_type command;
      logic        out_free;
      logic        full;
      logic        empty;
      logic        bad_index;
      logic        i_below;
      logic        i_plus_below;
      logic        j_zero;
      logic        rd_less;
      logic        key_match;
      logic        key_small;
      logic        sq_above;
      logic        div_done;
      logic        rem_zero;
      logic        pend_valid;
   } dp_status_type;

endpackage

// ===== rtl/core/bounded_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_array_table_engine
// Bounded list of signed words driven by one command per request transfer.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall/req_data (command, value, index);
// results leave on rsp_valid/rsp_stall/rsp_data, with last set on the final
// result of each command. One command is worked on at a time: req_stall is
// high from the cycle after a transfer until that command has handed its
// final result to the output register.
// Clear and append act in the dispatch step; list, search, delete and sort
// walk the store element by element, each step bounded by the single read
// and single write port of the store.
// List primes runs trial division in a bit-serial remainder unit, once per
// trial divisor up to the square root of each element.
// Reset empties the list and drops any pending result. A stalled result
// holds in the output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module bounded_array_table_engine
   import bate_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   bate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   bate_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/bate_ram.sv =====
// ----------------------------------------------------------------------------
// bate_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bate_divider.sv =====
// ----------------------------------------------------------------------------
// bate_divider
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bate_divider
   import bate_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic              rem_zero
);

   localparam int NW = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NW-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0] sh_ff, sh_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, sh_ff[WORD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = NW'(WORD_W - 1);
         sh_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = DIV_W'(trial);
         end
         sh_in  = {sh_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/core/bate_datapath.sv =====
// ----------------------------------------------------------------------------
// bate_datapath
// Element store, loop indices, prime trial state and the result register.
// ----------------------------------------------------------------------------
module bate_datapath
   import bate_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 6) ? CW : 6;

   command_type        command_ff, command_in;
   logic signed [31:0] value_ff, value_in;
   logic [5:0]         index_ff, index_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic signed [31:0] key_ff, key_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [4:0]         pend_pos_ff, pend_pos_in;
   logic signed [31:0] pend_elem_ff, pend_elem_in;
   logic [DIV_W-1:0]   d_ff, d_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [AW-1:0]      raddr, waddr;
   logic [WORD_W-1:0]  wdata, rdata;
   logic               div_done, rem_zero;
   logic               out_free, full, i_plus_below;

   bate_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (cmd.we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   bate_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (key_ff),
      .divisor  (d_ff),
      .done     (div_done),
      .rem_zero (rem_zero)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign full         = (count_ff >= CW'(DEPTH));
   assign i_plus_below = ({1'b0, i_ff} + 1'b1) < {1'b0, count_ff};

   always_comb begin
      unique case (cmd.raddr_sel)
         RA_I_PLUS:  raddr = AW'(i_ff + 1'b1);
         RA_J_MINUS: raddr = AW'(j_ff - 1'b1);
         default:    raddr = AW'(i_ff);
      endcase
      unique case (cmd.waddr_sel)
         WA_I:    waddr = AW'(i_ff);
         WA_J:    waddr = AW'(j_ff);
         default: waddr = AW'(count_ff);
      endcase
      unique case (cmd.wdata_sel)
         WD_RDATA: wdata = rdata;
         WD_KEY:   wdata = key_ff;
         default:  wdata = value_ff;
      endcase
   end

   always_comb begin
      command_in = command_ff;
      value_in   = value_ff;
      index_in   = index_ff;
      if (cmd.load_req) begin
         command_in = req_data.command;
         value_in   = req_data.value;
         index_in   = req_data.index;
      end

      unique case (cmd.i_op)
         IOP_ZERO:  i_in = '0;
         IOP_ONE:   i_in = CW'(1);
         IOP_INDEX: i_in = CW'(index_ff);
         IOP_INC:   i_in = i_ff + 1'b1;
         default:   i_in = i_ff;
      endcase

      unique case (cmd.j_op)
         JOP_LOAD_I: j_in = i_ff;
         JOP_DEC:    j_in = j_ff - 1'b1;
         default:    j_in = j_ff;
      endcase

      unique case (cmd.count_op)
         CNT_ZERO: count_in = '0;
         CNT_INC:  count_in = count_ff + 1'b1;
         CNT_DEC:  count_in = count_ff - 1'b1;
         default:  count_in = count_ff;
      endcase

      key_in = cmd.key_load ? $signed(rdata) : key_ff;

      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      pend_elem_in  = pend_elem_ff;
      unique case (cmd.pend_op)
         PEND_CLEAR: pend_valid_in = 1'b0;
         PEND_LOAD: begin
            pend_valid_in = 1'b1;
            pend_pos_in   = 5'(i_ff);
            pend_elem_in  = key_ff;
         end
         default: ;
      endcase

      d_in  = d_ff;
      sq_in = sq_ff;
      if (cmd.prime_init) begin
         d_in  = DIV_W'(2);
         sq_in = SQ_W'(4);
      end else if (cmd.prime_step) begin
         d_in  = d_ff + 1'b1;
         sq_in = sq_ff + SQ_W'({d_ff, 1'b1});
      end
   end

   // result register; element_count shows the count after this command
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.emit != EM_NONE) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = STAT_OK;
         rsp_in.position       = '0;
         rsp_in.element        = '0;
         rsp_in.element_count  = 6'(count_in);
         rsp_in.last           = 1'b1;
         unique case (cmd.emit)
            EM_APPEND: begin
               rsp_in.element = value_ff;
               if (full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  rsp_in.position = 5'(count_ff);
               end
            end
            EM_LIST: begin
               rsp_in.position = 5'(i_ff);
               rsp_in.element  = $signed(rdata);
               rsp_in.last     = !i_plus_below;
            end
            EM_EMPTY:    rsp_in.status = STAT_EMPTY;
            EM_BADINDEX: begin
               rsp_in.status   = STAT_BADINDEX;
               rsp_in.position = index_ff[4:0];
            end
            EM_DELETE: begin
               rsp_in.position = index_ff[4:0];
               rsp_in.element  = key_ff;
            end
            EM_PEND, EM_PEND_LAST: begin
               rsp_in.position = pend_pos_ff;
               rsp_in.element  = pend_elem_ff;
               rsp_in.last     = (cmd.emit == EM_PEND_LAST);
            end
            EM_NOTFOUND: begin
               rsp_in.status  = STAT_NOTFOUND;
               rsp_in.element = value_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      command_ff   <= command_in;
      value_ff     <= value_in;
      index_ff     <= index_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      key_ff       <= key_in;
      pend_pos_ff  <= pend_pos_in;
      pend_elem_ff <= pend_elem_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      status.command      = command_ff;
      status.out_free     = out_free;
      status.full         = full;
      status.empty        = (count_ff == '0);
      status.bad_index    = XW'(index_ff) >= XW'(count_ff);
      status.i_below      = (i_ff < count_ff);
      status.i_plus_below = i_plus_below;
      status.j_zero       = (j_ff == '0);
      status.rd_less      = $signed(rdata) < key_ff;
      status.key_match    = (key_ff == value_ff);
      status.key_small    = (key_ff < 32'sd2);
      status.sq_above     = sq_ff > {1'b0, key_ff};
      status.div_done     = div_done;
      status.rem_zero     = rem_zero;
      status.pend_valid   = pend_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/bate_ctrl.sv =====
// ----------------------------------------------------------------------------
// bate_ctrl
// Command sequencer: steps the datapath through each command's loops.
// ----------------------------------------------------------------------------
module bate_ctrl
   import bate_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_LIST_RD, S_LIST_EMIT,
      S_SCAN_RD, S_SCAN_KEY, S_SCAN_TEST, S_PRIME_LOOP, S_PRIME_WAIT,
      S_SCAN_HIT, S_SCAN_END,
      S_SORT_NEXT, S_SORT_KEY, S_SORT_CMP_RD, S_SORT_CMP, S_SORT_DONE,
      S_DEL_RD, S_DEL_KEY, S_DEL_SHIFT, S_DEL_MOVE, S_DEL_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.command)
               CMD_CLEAR: begin
                  if (status.out_free) begin
                     cmd.count_op = CNT_ZERO;
                     cmd.emit     = EM_CLEAR;
                     state_in     = S_IDLE;
                  end
               end
               CMD_APPEND: begin
                  if (status.out_free) begin
                     cmd.emit = EM_APPEND;
                     if (!status.full) begin
                        cmd.we        = 1'b1;
                        cmd.waddr_sel = WA_COUNT;
                        cmd.wdata_sel = WD_VALUE;
                        cmd.count_op  = CNT_INC;
                     end
                     state_in = S_IDLE;
                  end
               end
               CMD_LIST: begin
                  if (!status.empty) begin
                     cmd.i_op = IOP_ZERO;
                     state_in = S_LIST_RD;
                  end else if (status.out_free) begin
                     cmd.emit = EM_EMPTY;
                     state_in = S_IDLE;
                  end
               end
               CMD_PRIMES, CMD_SEARCH: begin
                  cmd.i_op    = IOP_ZERO;
                  cmd.pend_op = PEND_CLEAR;
                  state_in    = S_SCAN_RD;
               end
               CMD_SORT: begin
                  cmd.i_op = IOP_ONE;
                  state_in = S_SORT_NEXT;
               end
               CMD_DELETE: begin
                  if (!status.bad_index) begin
                     cmd.i_op = IOP_INDEX;
                     state_in = S_DEL_RD;
                  end else if (status.out_free) begin
                     cmd.emit = EM_BADINDEX;
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;   // unused code: drop
            endcase
         end

         S_LIST_RD: state_in = S_LIST_EMIT;
         S_LIST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = EM_LIST;
               if (status.i_plus_below) begin
                  cmd.i_op = IOP_INC;
                  state_in = S_LIST_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_SCAN_RD: state_in = status.i_below ? S_SCAN_KEY : S_SCAN_END;
         S_SCAN_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = S_SCAN_TEST;
         end
         S_SCAN_TEST: begin
            if (status.command == CMD_SEARCH) begin
               if (status.key_match) begin
                  state_in = S_SCAN_HIT;
               end else begin
                  cmd.i_op = IOP_INC;
                  state_in = S_SCAN_RD;
               end
            end else if (status.key_small) begin
               cmd.i_op = IOP_INC;
               state_in = S_SCAN_RD;
            end else begin
               cmd.prime_init = 1'b1;
               state_in       = S_PRIME_LOOP;
            end
         end
         S_PRIME_LOOP: begin
            if (status.sq_above) begin
               state_in = S_SCAN_HIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_PRIME_WAIT;
            end
         end
         S_PRIME_WAIT: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.i_op = IOP_INC;
                  state_in = S_SCAN_RD;
               end else begin
                  cmd.prime_step = 1'b1;
                  state_in       = S_PRIME_LOOP;
               end
            end
         end
         // hold one hit back so the final one can carry the last marker
         S_SCAN_HIT: begin
            if (!status.pend_valid || status.out_free) begin
               if (status.pend_valid) begin
                  cmd.emit = EM_PEND;
               end
               cmd.pend_op = PEND_LOAD;
               cmd.i_op    = IOP_INC;
               state_in    = S_SCAN_RD;
            end
         end
         S_SCAN_END: begin
            if (status.out_free) begin
               if (status.pend_valid) begin
                  cmd.emit = EM_PEND_LAST;
               end else if (status.command == CMD_SEARCH) begin
                  cmd.emit = EM_NOTFOUND;
               end else begin
                  cmd.emit = EM_EMPTY;
               end
               state_in = S_IDLE;
            end
         end

         S_SORT_NEXT: state_in = status.i_below ? S_SORT_KEY : S_SORT_DONE;
         S_SORT_KEY: begin
            cmd.key_load = 1'b1;
            cmd.j_op     = JOP_LOAD_I;
            state_in     = S_SORT_CMP_RD;
         end
         S_SORT_CMP_RD: begin
            cmd.raddr_sel = RA_J_MINUS;
            if (status.j_zero) begin
               cmd.we        = 1'b1;
               cmd.waddr_sel = WA_J;
               cmd.wdata_sel = WD_KEY;
               cmd.i_op      = IOP_INC;
               state_in      = S_SORT_NEXT;
            end else begin
               state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            cmd.raddr_sel = RA_J_MINUS;
            cmd.we        = 1'b1;
            cmd.waddr_sel = WA_J;
            if (status.rd_less) begin
               cmd.wdata_sel = WD_RDATA;
               cmd.j_op      = JOP_DEC;
               state_in      = S_SORT_CMP_RD;
            end else begin
               cmd.wdata_sel = WD_KEY;
               cmd.i_op      = IOP_INC;
               state_in      = S_SORT_NEXT;
            end
         end
         S_SORT_DONE: begin
            if (status.out_free) begin
               cmd.emit = EM_SORTED;
               state_in = S_IDLE;
            end
         end

         S_DEL_RD: state_in = S_DEL_KEY;
         S_DEL_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = S_DEL_SHIFT;
         end
         S_DEL_SHIFT: begin
            cmd.raddr_sel = RA_I_PLUS;
            state_in      = status.i_plus_below ? S_DEL_MOVE : S_DEL_DONE;
         end
         S_DEL_MOVE: begin
            cmd.we        = 1'b1;
            cmd.waddr_sel = WA_I;
            cmd.wdata_sel = WD_RDATA;
            cmd.i_op      = IOP_INC;
            state_in      = S_DEL_SHIFT;
         end
         S_DEL_DONE: begin
            if (status.out_free) begin
               cmd.count_op = CNT_DEC;
               cmd.emit     = EM_DELETE;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== bench/tb_bounded_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_array_table_engine
// Self-checking bench for the bounded array table engine. A directed table
// exercises empty, bad-index, not-found and ignored-code cases, then
// random command streams run under several idle/stall mixes. Every result
// is checked against the in-bench list model or a hand-written table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_array_table_engine;
   import bate_pkg::*;

   localparam int LIST_DEPTH = 32;

   typedef struct {
      command_type        command;
      logic signed [31:0] value;
      logic [5:0]         index;
      bit                 typed;
      status_type         status;
      logic [4:0]         position;
      logic signed [31:0] element;
      logic [5:0]         element_count;
   } table_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic signed [31:0] list_words[LIST_DEPTH];
   int                 list_count = 0;
   rsp_type            pending_results[$];
   int                 mismatches = 0;
   int                 results_seen = 0;
   int                 items_sent = 0;
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   table_row_type      dir_tab[25];

   bounded_array_table_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit word_prime(logic signed [31:0] w);
      longint n;
      longint d;
      if (w < 2) return 1'b0;
      n = w;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type make_result(status_type s, int pos, logic signed [31:0] e,
                                           bit fin);
      rsp_type r;
      r.status        = s;
      r.position      = pos[4:0];
      r.element       = e;
      r.element_count = list_count[5:0];
      r.last          = fin;
      return r;
   endfunction

   // Update the list copy and queue the results one command causes.
   function automatic void predict_list_command(req_type q);
      int                 hits;
      int                 j;
      logic signed [31:0] key;
      hits = 0;
      case (q.command)
         CMD_CLEAR: begin
            list_count = 0;
            pending_results.push_back(make_result(STAT_OK, 0, 0, 1'b1));
         end
         CMD_APPEND: begin
            if (list_count >= LIST_DEPTH) begin
               pending_results.push_back(make_result(STAT_FULL, 0, q.value, 1'b1));
            end else begin
               list_words[list_count] = q.value;
               list_count++;
               pending_results.push_back(make_result(STAT_OK, list_count - 1, q.value,
                                                     1'b1));
            end
         end
         CMD_LIST: begin
            if (list_count == 0)
               pending_results.push_back(make_result(STAT_EMPTY, 0, 0, 1'b1));
            for (int i = 0; i < list_count; i++)
               pending_results.push_back(make_result(STAT_OK, i, list_words[i],
                                                     i + 1 == list_count));
         end
         CMD_PRIMES, CMD_SEARCH: begin
            for (int i = 0; i < list_count; i++) begin
               if (q.command == CMD_PRIMES ? word_prime(list_words[i])
                                           : list_words[i] == q.value) begin
                  pending_results.push_back(make_result(STAT_OK, i, list_words[i], 1'b0));
                  hits++;
               end
            end
            if (hits == 0) begin
               if (q.command == CMD_PRIMES)
                  pending_results.push_back(make_result(STAT_EMPTY, 0, 0, 1'b1));
               else
                  pending_results.push_back(make_result(STAT_NOTFOUND, 0, q.value, 1'b1));
            end else begin
               pending_results[$].last = 1'b1;
            end
         end
         CMD_SORT: begin
            for (int i = 1; i < list_count; i++) begin
               key = list_words[i];
               j = i;
               while (j > 0 && list_words[j - 1] < key) begin
                  list_words[j] = list_words[j - 1];
                  j--;
               end
               list_words[j] = key;
            end
            pending_results.push_back(make_result(STAT_OK, 0, 0, 1'b1));
         end
         CMD_DELETE: begin
            if (q.index >= list_count) begin
               pending_results.push_back(make_result(STAT_BADINDEX, q.index, 0, 1'b1));
            end else begin
               key = list_words[q.index];
               for (int i = q.index; i + 1 < list_count; i++)
                  list_words[i] = list_words[i + 1];
               list_count--;
               pending_results.push_back(make_result(STAT_OK, q.index, key, 1'b1));
            end
         end
         default: ;
      endcase
   endfunction

   // Hold the request until a transfer; valid stays high for a following item.
   task automatic send_item(req_type q);
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_list_command(q);
      items_sent++;
   endtask

   task automatic idle_gap();
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Large positive words are kept even so that prime listing stays short.
   function automatic logic signed [31:0] random_word();
      logic [31:0] w;
      int          pick;
      w = $urandom;
      pick = $urandom_range(9);
      if (list_count > 0 && pick < 2) return list_words[$urandom_range(list_count - 1)];
      if (pick < 6) return $signed(32'($urandom_range(511))) - 32'sd100;
      if (pick < 8) return $signed({1'b1, w[30:0]});
      return $signed({1'b0, w[30:1], 1'b0});
   endfunction

   function automatic req_type random_item(int append_weight);
      req_type q;
      int      pick;
      q.value = random_word();
      q.index = (list_count > 0 && $urandom_range(3) != 0) ?
                6'($urandom_range(list_count - 1)) : 6'($urandom_range(63));
      pick = $urandom_range(append_weight + 65);
      if (pick < append_weight)           q.command = CMD_APPEND;
      else if (pick < append_weight + 10) q.command = CMD_LIST;
      else if (pick < append_weight + 16) q.command = CMD_PRIMES;
      else if (pick < append_weight + 24) q.command = CMD_SORT;
      else if (pick < append_weight + 40) q.command = CMD_DELETE;
      else if (pick < append_weight + 58) q.command = CMD_SEARCH;
      else if (pick < append_weight + 62) q.command = CMD_CLEAR;
      else                                q.command = command_type'(3'd7);
      return q;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: %p", rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d pos=%0d el=%0d cnt=%0d last=%0b, got st=%0d pos=%0d el=%0d cnt=%0d last=%0b",
                           want.status, want.position, want.element, want.element_count,
                           want.last, rsp_data.status, rsp_data.position,
                           rsp_data.element, rsp_data.element_count, rsp_data.last);
            end
         end
      end
   end

   initial begin
      #400_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_type q;
      int      wait_cycles;
      dir_tab = '{
         '{CMD_LIST,   0,  0, 1, STAT_EMPTY,    0, 0, 0},
         '{CMD_PRIMES, 0,  0, 0, STAT_OK,       0, 0, 0},
         '{CMD_DELETE, 0, 63, 1, STAT_BADINDEX, 31, 0, 0},
         '{CMD_SEARCH, 7,  0, 1, STAT_NOTFOUND, 0, 7, 0},
         '{CMD_APPEND, 32'sh8000_0000, 63, 1, STAT_OK, 0, 32'sh8000_0000, 1},
         '{CMD_APPEND, 32'sh7FFF_FFFE, 0, 1, STAT_OK, 1, 32'sh7FFF_FFFE, 2},
         '{CMD_APPEND, 2,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_APPEND, 97, 0, 0, STAT_OK, 0, 0, 0},
         '{CMD_APPEND, 1,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_APPEND, 0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_APPEND, -1, 0, 0, STAT_OK, 0, 0, 0},
         '{CMD_APPEND, 97, 0, 0, STAT_OK, 0, 0, 0},
         '{CMD_APPEND, 2,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_LIST,   0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_PRIMES, 0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_SORT,   0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_LIST,   0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_SEARCH, 97, 0, 0, STAT_OK, 0, 0, 0},
         '{CMD_DELETE, 0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_DELETE, 0, 63, 1, STAT_BADINDEX, 31, 0, 8},
         '{command_type'(3'd7), -1, 63, 0, STAT_OK, 0, 0, 0},
         '{CMD_DELETE, 0,  7, 0, STAT_OK, 0, 0, 0},
         '{CMD_LIST,   0,  0, 0, STAT_OK, 0, 0, 0},
         '{CMD_CLEAR,  0,  0, 1, STAT_OK, 0, 0, 0},
         '{CMD_SORT,   0,  0, 0, STAT_OK, 0, 0, 0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[n]) begin
         q.command = dir_tab[n].command;
         q.value   = dir_tab[n].value;
         q.index   = dir_tab[n].index;
         send_item(q);
         // Swap the model's answer for the hand-written one.
         if (dir_tab[n].typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back('{dir_tab[n].status, dir_tab[n].position,
                                        dir_tab[n].element, dir_tab[n].element_count,
                                        1'b1});
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 30 : 0;
         stall_pct = (phase == 2) ? 75 : (phase == 3) ? 30 : 0;
         for (int n = 0; n < 85; n++) begin
            q = random_item(phase == 0 ? 90 : 35);
            idle_gap();
            send_item(q);
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 5_000_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);

      $display("Sent %0d commands (directed table plus four idle/stall mixes),",
               items_sent);
      $display("checked %0d result transfers, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
